// ----- rtl/epk_pkg.sv -----
`default_nettype none
package epk_pkg;

	localparam int unsigned GROUP_LEN = 7;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] LAST_SLOT = 3'd6;
	localparam logic [6:0] TOP_FIRST_BIT = 7'h40;
	localparam logic [6:0] LOW_MASK = 7'h7f;

	localparam logic [3:0] MATCH_TEXT_END = 4'd9;
	localparam logic [3:0] MATCH_CAP_MAJOR = 4'd9;
	localparam logic [3:0] MATCH_SKIP_DOT = 4'd10;
	localparam logic [3:0] MATCH_CAP_TENS = 4'd11;
	localparam logic [3:0] MATCH_CAP_UNITS = 4'd12;
	localparam logic [3:0] MATCH_DONE = 4'd13;

	localparam logic [7:0] MAJOR_RESET = 8'h58;
	localparam logic [7:0] TENS_RESET = 8'h59;
	localparam logic [7:0] UNITS_RESET = 8'h5a;

	typedef logic [6:0] low_t;

	typedef struct packed {
		logic [6:0]            top;
		low_t [GROUP_LEN-1:0]  low;
		logic [2:0]            count;
		logic                  found;
		logic [7:0]            major;
		logic [7:0]            tens;
		logic [7:0]            units;
	} group_t;

	function automatic logic [7:0] match_char(input logic [3:0] step);
		logic [7:0] c;
		case (step)
			4'd0: c = 8'h56;
			4'd1: c = 8'h45;
			4'd2: c = 8'h52;
			4'd3: c = 8'h53;
			4'd4: c = 8'h49;
			4'd5: c = 8'h4f;
			4'd6: c = 8'h4e;
			4'd7: c = 8'h3a;
			4'd8: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/epk_feed_if.sv -----
`default_nettype none
interface epk_feed_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/epk_result_if.sv -----
`default_nettype none
interface epk_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] packed_byte;
	logic       group_end;
	logic       version_found;
	logic [7:0] version_major_char;
	logic [7:0] version_tens_char;
	logic [7:0] version_units_char;

	modport source (output valid, output packed_byte, output group_end,
		output version_found, output version_major_char,
		output version_tens_char, output version_units_char, input ready);
	modport sink (input valid, input packed_byte, input group_end,
		input version_found, input version_major_char,
		input version_tens_char, input version_units_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/epk_front.sv -----
`default_nettype none
module epk_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	epk_feed_if.sink         feed,
	input  wire logic        full,
	output logic             push,
	output epk_pkg::group_t  group
);

	logic [6:0]         top_q;
	epk_pkg::low_t      store_q [epk_pkg::GROUP_LEN];
	logic [2:0]         fill_q;
	logic [3:0]         step_q;
	logic [7:0]         major_q;
	logic [7:0]         tens_q;
	logic [7:0]         units_q;

	logic               accept;
	logic [6:0]         top_n;
	logic [2:0]         fill_n;
	logic [3:0]         step_n;
	logic [7:0]         major_n;
	logic [7:0]         tens_n;
	logic [7:0]         units_n;
	logic               emit;

	assign feed.ready = !full;
	assign accept = feed.valid && feed.ready;

	always_comb begin
		step_n = step_q;
		major_n = major_q;
		tens_n = tens_q;
		units_n = units_q;
		if (step_q < epk_pkg::MATCH_TEXT_END) begin
			step_n = (feed.data_byte == epk_pkg::match_char(step_q)) ? step_q + 4'd1 : 4'd0;
		end else begin
			case (step_q)
				epk_pkg::MATCH_CAP_MAJOR: begin
					major_n = feed.data_byte;
					step_n = epk_pkg::MATCH_SKIP_DOT;
				end
				epk_pkg::MATCH_SKIP_DOT: step_n = epk_pkg::MATCH_CAP_TENS;
				epk_pkg::MATCH_CAP_TENS: begin
					tens_n = feed.data_byte;
					step_n = epk_pkg::MATCH_CAP_UNITS;
				end
				epk_pkg::MATCH_CAP_UNITS: begin
					units_n = feed.data_byte;
					step_n = epk_pkg::MATCH_DONE;
				end
				default: step_n = step_q;
			endcase
		end
	end

	always_comb begin
		top_n = top_q | (feed.data_byte[7] ? (epk_pkg::TOP_FIRST_BIT >> fill_q) : 7'd0);
		fill_n = fill_q + 3'd1;
		emit = (fill_q == epk_pkg::LAST_SLOT) || feed.final_byte;
		push = accept && emit;
		group.top = top_n;
		for (int i = 0; i < epk_pkg::GROUP_LEN; i++) begin
			group.low[i] = (3'(i) == fill_q) ? (feed.data_byte[6:0] & epk_pkg::LOW_MASK)
				: store_q[i];
		end
		group.count = fill_n;
		group.found = (step_n == epk_pkg::MATCH_DONE);
		group.major = major_n;
		group.tens = tens_n;
		group.units = units_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			fill_q <= '0;
			step_q <= '0;
			major_q <= epk_pkg::MAJOR_RESET;
			tens_q <= epk_pkg::TENS_RESET;
			units_q <= epk_pkg::UNITS_RESET;
		end else if (accept) begin
			step_q <= step_n;
			major_q <= major_n;
			tens_q <= tens_n;
			units_q <= units_n;
			if (emit) begin
				top_q <= '0;
				fill_q <= '0;
			end else begin
				top_q <= top_n;
				fill_q <= fill_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[fill_q] <= feed.data_byte[6:0];
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= epk_pkg::LAST_SLOT)
		else $error("fill count past group length");

endmodule
`default_nettype wire

// ----- rtl/epk_queue.sv -----
`default_nettype none
module epk_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire epk_pkg::group_t  wr_group,
	input  wire logic             pop,
	output epk_pkg::group_t       rd_group,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PTR_W = $clog2(epk_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(epk_pkg::QUEUE_DEPTH + 1);

	epk_pkg::group_t   mem [epk_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_W'(epk_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_group = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(epk_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(epk_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_group;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("group queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("group queue underflow");

endmodule
`default_nettype wire

// ----- rtl/epk_back.sv -----
`default_nettype none
module epk_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire epk_pkg::group_t  group,
	input  wire logic             empty,
	output logic                  pop,
	epk_result_if.source          result
);

	epk_pkg::group_t  cur_q;
	logic             busy_q;
	logic [2:0]       pos_q;
	logic             out_valid_q;
	logic [6:0]       byte_q;
	logic             end_q;
	logic             found_q;
	logic [7:0]       major_q;
	logic [7:0]       tens_q;
	logic [7:0]       units_q;

	logic             advance;
	logic             last;
	logic [2:0]       low_idx;

	assign advance = !out_valid_q || result.ready;
	assign last = (pos_q == cur_q.count);
	assign pop = !empty && (!busy_q || (advance && last));
	assign low_idx = pos_q - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				pos_q <= '0;
			end else if (advance && busy_q) begin
				pos_q <= pos_q + 3'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= group;
		end
		if (advance && busy_q) begin
			byte_q <= (pos_q == '0) ? cur_q.top : cur_q.low[low_idx];
			end_q <= last;
			found_q <= cur_q.found;
			major_q <= cur_q.major;
			tens_q <= cur_q.tens;
			units_q <= cur_q.units;
		end
	end

	assign result.valid = out_valid_q;
	assign result.packed_byte = byte_q;
	assign result.group_end = end_q;
	assign result.version_found = found_q;
	assign result.version_major_char = major_q;
	assign result.version_tens_char = tens_q;
	assign result.version_units_char = units_q;

	a_pos_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= cur_q.count && cur_q.count != 3'd0))
		else $error("beat position past group size");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> (advance && last))
		else $error("group loaded over an unfinished one");

endmodule
`default_nettype wire

// ----- rtl/eight_to_seven_bit_packer.sv -----
`default_nettype none
// Packs 8-bit payload bytes into 7-bit-clean groups: a top-bits byte, then
// up to seven low bytes, with group_end on the last beat of each group and
// the captured version text carried on every beat. The front takes one input
// beat per cycle while its two-entry group queue has room; the back emits one
// output beat per cycle from the queue head while result.ready lets it, so a
// full group of seven input bytes gives eight output beats and a partial group
// flushed by final_byte gives one beat more than the bytes it holds, so the
// single-byte output channel bounds the sustained input rate. The first beat
// of a group passes the queue, then the back's group and output registers.
module eight_to_seven_bit_packer (
	input  wire logic      clk,
	input  wire logic      arst_n,
	epk_feed_if.sink       feed,
	epk_result_if.source   result
);

	epk_pkg::group_t  wr_group;
	epk_pkg::group_t  rd_group;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;

	epk_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.full   (full),
		.push   (push),
		.group  (wr_group)
	);

	epk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_group (wr_group),
		.pop      (pop),
		.rd_group (rd_group),
		.full     (full),
		.empty    (empty)
	);

	epk_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.group  (rd_group),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

// ----- dv/eight_to_seven_bit_packer_test.sv -----
`default_nettype none
module eight_to_seven_bit_packer_test;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned LONG_STALL = 300;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned RANDOM_ITEMS = 390;
	localparam int unsigned MAX_REPORTS = 30;
	localparam int unsigned N_DIRECTED = 21;

	localparam logic [7:0] VERSION_TEXT [9] = '{"V", "E", "R", "S", "I", "O", "N", ":", " "};

	typedef struct packed {
		logic [6:0] packed_byte;
		logic       group_end;
		logic       found;
		logic [7:0] major;
		logic [7:0] tens;
		logic [7:0] units;
	} beat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
		logic       typed;
		logic [6:0] top;
		logic [6:0] low;
	} row_t;

	typedef struct packed {
		row_t row;
		logic hold;
		logic stall;
	} item_t;

	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{8'hff, 1'b1, 1'b1, 7'h40, 7'h7f},
		'{8'h00, 1'b1, 1'b1, 7'h00, 7'h00},
		'{8'h80, 1'b1, 1'b1, 7'h40, 7'h00},
		'{8'h7f, 1'b1, 1'b1, 7'h00, 7'h7f},
		'{8'h80, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'h01, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'hff, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'h7f, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'hc3, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'h3c, 1'b0, 1'b0, 7'h00, 7'h00},
		'{8'h81, 1'b1, 1'b0, 7'h00, 7'h00},
		'{"V", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"V", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"E", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"R", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"S", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"I", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"O", 1'b0, 1'b0, 7'h00, 7'h00},
		'{"N", 1'b0, 1'b0, 7'h00, 7'h00},
		'{":", 1'b0, 1'b0, 7'h00, 7'h00},
		'{" ", 1'b1, 1'b0, 7'h00, 7'h00}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	epk_feed_if feed();
	epk_result_if result();

	eight_to_seven_bit_packer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed),
		.result(result)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	item_t stim [$];
	beat_t expected_beats [$];

	logic [6:0] top_bits;
	logic [6:0] low_bytes [epk_pkg::GROUP_LEN];
	logic [2:0] held;
	logic [3:0] match_pos;
	logic [7:0] ver_major;
	logic [7:0] ver_tens;
	logic [7:0] ver_units;

	int unsigned errors;
	int unsigned items_in;
	int unsigned beats_out;
	int unsigned full_groups;
	int unsigned partial_groups;
	int unsigned stalls_asked;
	int unsigned stalls_done;
	int unsigned idle_cycles;

	initial begin
		top_bits = '0;
		held = '0;
		match_pos = '0;
		ver_major = epk_pkg::MAJOR_RESET;
		ver_tens = epk_pkg::TENS_RESET;
		ver_units = epk_pkg::UNITS_RESET;
		errors = 0;
		items_in = 0;
		beats_out = 0;
		full_groups = 0;
		partial_groups = 0;
		stalls_asked = 0;
		idle_cycles = 0;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at %0t, beat %0d: %s", $time, beats_out, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, want %h", name, got, want));
	endtask

	function automatic beat_t make_beat(input logic [6:0] value, input logic last);
		return '{value, last, match_pos == epk_pkg::MATCH_DONE,
			ver_major, ver_tens, ver_units};
	endfunction

	task automatic pack_byte(input row_t r);
		int unsigned i;
		if (match_pos < epk_pkg::MATCH_TEXT_END) begin
			match_pos = (r.data_byte == VERSION_TEXT[match_pos]) ? match_pos + 4'd1 : 4'd0;
		end else begin
			case (match_pos)
				epk_pkg::MATCH_CAP_MAJOR: begin
					ver_major = r.data_byte;
					match_pos = epk_pkg::MATCH_SKIP_DOT;
				end
				epk_pkg::MATCH_SKIP_DOT: match_pos = epk_pkg::MATCH_CAP_TENS;
				epk_pkg::MATCH_CAP_TENS: begin
					ver_tens = r.data_byte;
					match_pos = epk_pkg::MATCH_CAP_UNITS;
				end
				epk_pkg::MATCH_CAP_UNITS: begin
					ver_units = r.data_byte;
					match_pos = epk_pkg::MATCH_DONE;
				end
				default: ;
			endcase
		end
		if (r.data_byte[7])
			top_bits = top_bits | (epk_pkg::TOP_FIRST_BIT >> held);
		low_bytes[held] = r.data_byte[6:0] & epk_pkg::LOW_MASK;
		held = held + 3'd1;
		if (held == epk_pkg::GROUP_LEN || r.final_byte) begin
			if (held == epk_pkg::GROUP_LEN)
				full_groups++;
			else
				partial_groups++;
			expected_beats.push_back(make_beat(top_bits, 1'b0));
			for (i = 0; i < held; i++)
				expected_beats.push_back(make_beat(low_bytes[i], i + 1 == held));
			top_bits = '0;
			held = '0;
		end
		if (r.typed) begin
			expected_beats[expected_beats.size() - 2] = '{r.top, 1'b0, 1'b0,
				epk_pkg::MAJOR_RESET, epk_pkg::TENS_RESET, epk_pkg::UNITS_RESET};
			expected_beats[expected_beats.size() - 1] = '{r.low, 1'b1, 1'b0,
				epk_pkg::MAJOR_RESET, epk_pkg::TENS_RESET, epk_pkg::UNITS_RESET};
		end
	endtask

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n) begin
			if (feed.valid && feed.ready) begin
				pack_byte(stim[items_in].row);
				items_in++;
			end
			if (result.valid && result.ready) begin
				got = '{result.packed_byte, result.group_end, result.version_found,
					result.version_major_char, result.version_tens_char,
					result.version_units_char};
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat %h", got));
				end else begin
					want = expected_beats.pop_front();
					check_field("packed_byte", 8'(got.packed_byte), 8'(want.packed_byte));
					check_field("group_end", 8'(got.group_end), 8'(want.group_end));
					check_field("version_found", 8'(got.found), 8'(want.found));
					check_field("version_major_char", got.major, want.major);
					check_field("version_tens_char", got.tens, want.tens);
					check_field("version_units_char", got.units, want.units);
				end
				beats_out++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed.valid && feed.ready) || (result.valid && result.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles == IDLE_LIMIT) begin
					$display("no beat moved for %0d cycles", IDLE_LIMIT);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	task automatic add_byte(input logic [7:0] b);
		item_t it;
		it = '0;
		it.row.data_byte = b;
		it.row.final_byte = ($urandom_range(0, 5) == 0);
		stim.push_back(it);
	endtask

	initial begin
		int unsigned mode;
		int unsigned mode_left;
		logic [7:0] rot;
		result.ready <= 1'b0;
		stalls_done = 0;
		mode = 0;
		mode_left = 0;
		rot = 8'b1011_0010;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stalls_done != stalls_asked) begin
				stalls_done = stalls_asked;
				result.ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
				0: result.ready <= 1'b1;
				1: result.ready <= 1'($urandom_range(0, 1));
				2: begin
					rot = {rot[6:0], rot[7]};
					result.ready <= rot[0];
				end
				default: result.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		item_t it;
		int unsigned k;
		int unsigned j;
		int unsigned texts_sent;
		int unsigned idx;
		int unsigned burst_left;
		int unsigned gap;
		logic [7:0] b;

		feed.valid <= 1'b0;
		feed.data_byte <= '0;
		feed.final_byte <= 1'b0;

		foreach (DIRECTED[r]) begin
			it = '0;
			it.row = DIRECTED[r];
			stim.push_back(it);
		end
		texts_sent = 0;
		while (stim.size() < N_DIRECTED + RANDOM_ITEMS) begin
			if ((texts_sent == 0 && stim.size() >= N_DIRECTED + 170) ||
					(texts_sent == 1 && stim.size() >= N_DIRECTED + 300)) begin
				for (j = 0; j < 9; j++)
					add_byte(VERSION_TEXT[j]);
				add_byte(8'($urandom_range(0, 255)));
				add_byte(".");
				add_byte(8'($urandom_range(0, 255)));
				add_byte(8'($urandom_range(0, 255)));
				texts_sent++;
			end else if ($urandom_range(0, 9) < 3) begin
				// broken prefix of the version text
				k = $urandom_range(1, 8);
				for (j = 0; j < k; j++)
					add_byte(VERSION_TEXT[j]);
				if ($urandom_range(0, 1)) begin
					b = "V";
				end else begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == VERSION_TEXT[k]);
				end
				add_byte(b);
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
		stim[stim.size() - 1].row.final_byte = 1'b1;
		stim[N_DIRECTED].hold = 1'b1;
		stim[N_DIRECTED + 100].stall = 1'b1;
		stim[N_DIRECTED + 260].hold = 1'b1;

		@(posedge arst_n);
		@(negedge clk);
		idx = 0;
		burst_left = 0;
		while (idx < stim.size()) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					feed.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			if (stim[idx].hold) begin
				feed.valid <= 1'b0;
				@(negedge clk);
				while (expected_beats.size() != 0)
					@(negedge clk);
			end
			if (stim[idx].stall)
				stalls_asked++;
			feed.valid <= 1'b1;
			feed.data_byte <= stim[idx].row.data_byte;
			feed.final_byte <= stim[idx].row.final_byte;
			@(posedge clk);
			while (!feed.ready)
				@(posedge clk);
			idx++;
			burst_left--;
			@(negedge clk);
		end
		feed.valid <= 1'b0;

		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d bytes, checked %0d output beats: %0d full groups, %0d partial flushes",
			items_in, beats_out, full_groups, partial_groups);
		$display("version text %s, captured chars %h %h %h",
			(match_pos == epk_pkg::MATCH_DONE) ? "found" : "not found",
			ver_major, ver_tens, ver_units);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
